// ===== hw/rtl/hapi_pkg.sv =====
// ============================================================================
// hapi_pkg - shared types and constants for the hitch angle PI loop
// Field widths, register indexes, fixed-point constants and the request and
// response records of the digit-serial multiplier.
// ============================================================================
package hapi_pkg;

    // Field widths
    localparam int ANGLE_W    = 16;   // Q3.12 radians
    localparam int SPEED_W    = 16;   // Q8.8
    localparam int GAIN_W     = 16;   // Q8.8 unsigned
    localparam int LIMIT_W    = 15;   // Q3.12 unsigned
    localparam int PERIOD_W   = 16;   // Q0.16 unsigned
    localparam int SPAN_W     = 7;
    localparam int CENTER_W   = 8;
    localparam int STEER_W    = 16;   // Q2.14
    localparam int SERVO_W    = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_MAX_TARGET   = 3'd2,
        CFG_TICK_PERIOD  = 3'd3,
        CFG_SERVO_SPAN   = 3'd4,
        CFG_SERVO_CENTER = 3'd5
    } cfg_idx_t;

    // Register reset values
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST    = 16'd256;
    localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST   = 16'd0;
    localparam logic [LIMIT_W-1:0]  MAX_TARGET_RST   = 15'd4096;
    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST  = 16'd655;
    localparam logic [SPAN_W-1:0]   SERVO_SPAN_RST   = 7'd30;
    localparam logic [CENTER_W-1:0] SERVO_CENTER_RST = 8'd90;

    // Integrator default width
    localparam int INTEG_WIDTH_DEF = 32;

    // Error word: limited target minus measured angle
    localparam int ERR_W = ANGLE_W + 1;

    // Fixed-point limits
    localparam int UNITY_Q14 = 16384;
    localparam int SERVO_MAX = 180;

    // Serial multiplier: wide multiplicand, 16 bit multiplier, 4 bit digits
    localparam int PROD_W      = 64;
    localparam int MPLIER_W    = 16;
    localparam int DIGIT_W     = 4;
    localparam int MUL_CNT_W   = 3;
    localparam int MUL_DIGITS  = MPLIER_W / DIGIT_W;
    localparam int SPAN_DIGITS = (SPAN_W + DIGIT_W - 1) / DIGIT_W;

    typedef struct packed {
        logic                        start;
        logic                        is_signed;
        logic [MUL_CNT_W-1:0]        digits;
        logic signed [PROD_W-1:0]    mcand;
        logic [MPLIER_W-1:0]         mplier;
    } mul_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [PROD_W-1:0]    product;
    } mul_rsp_t;

endpackage

// ===== hw/rtl/hapi_if.sv =====
// ============================================================================
// hapi_if - channel interfaces of the hitch angle PI loop
// Sample input, result output and register write channels, each with
// valid/ready and a source and a sink modport.
// ============================================================================
interface hapi_sample_if import hapi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] target_angle;
    logic signed [ANGLE_W-1:0] measured_angle;
    logic signed [SPEED_W-1:0] vehicle_speed;

    modport source (output valid, target_angle, measured_angle, vehicle_speed,
                    input ready);
    modport sink   (input valid, target_angle, measured_angle, vehicle_speed,
                    output ready);
endinterface

interface hapi_result_if import hapi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [STEER_W-1:0] steer_command;
    logic [SERVO_W-1:0]        servo_degrees;
    logic                      integ_held;

    modport source (output valid, steer_command, servo_degrees, integ_held,
                    input ready);
    modport sink   (input valid, steer_command, servo_degrees, integ_held,
                    output ready);
endinterface

interface hapi_cfg_if import hapi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hapi_serial_mul.sv =====
// ============================================================================
// hapi_serial_mul - digit-serial signed multiplier
// Retires one 4 bit digit of the multiplier per cycle, LSB first, into a
// 64 bit accumulator; the multiplicand shifts left one digit per cycle.
// ============================================================================
module hapi_serial_mul import hapi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [MUL_CNT_W-1:0]     cnt_reg;
    logic                     signed_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] mcand_reg;
    logic [MPLIER_W-1:0]      mplier_reg;

    logic                     last_digit;
    logic signed [DIGIT_W:0]  digit;
    logic signed [PROD_W-1:0] partial;

    // Current digit; the top digit of a signed multiplier carries weight -8
    assign last_digit = (cnt_reg == MUL_CNT_W'(1));
    assign digit      = {last_digit & signed_reg & mplier_reg[DIGIT_W-1],
                         mplier_reg[DIGIT_W-1:0]};
    assign partial    = mcand_reg * digit;

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.digits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - MUL_CNT_W'(1);
                if (last_digit)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: accumulate one partial product and shift one digit
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= req.mcand;
            mplier_reg <= req.mplier;
            signed_reg <= req.is_signed;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + partial;
            mcand_reg  <= mcand_reg <<< DIGIT_W;
            mplier_reg <= mplier_reg >> DIGIT_W;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== hw/rtl/hitch_angle_pi_steering_loop.sv =====
// ============================================================================
// hitch_angle_pi_steering_loop - PI hitch angle controller, clamping windup
// One control tick per sample beat: limits the target, runs the PI law with
// a speed-scaled integral term, clamps the command and maps it to the servo.
// ============================================================================
// Usage
//   sample : target_angle, measured_angle (Q3.12), vehicle_speed (Q8.8).
//   result : steer_command (Q2.14, +-1.0), servo_degrees, integ_held.
//   cfg    : register writes (index, data); always ready, write only while
//            no tick is in flight.
// Timing
//   A sample beat is taken only when the controller is idle. The five
//   products of a tick run one after another on one 4 bit digit-serial
//   multiplier: four 16 bit products and the servo product on the 7 bit
//   span. The result is loaded into the output register from the final
//   state, and no new sample is taken until that tick has returned to
//   idle.
// Stall
//   The result sits in an output register; a new sample is accepted while
//   it waits. A tick that finishes while the previous result is still not
//   taken waits in its final state until the output register frees.
// Reset
//   Registers return to their reset values and the integrator clears to 0.
// ============================================================================
module hitch_angle_pi_steering_loop import hapi_pkg::*;
#(
    parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    hapi_sample_if.sink   sample,
    hapi_result_if.source result,
    hapi_cfg_if.sink      cfg
);

    localparam int INC_W   = 30;
    localparam int SUM_W   = ((INTEG_WIDTH > INC_W) ? INTEG_WIDTH : INC_W) + 1;
    localparam int PTERM_W = 28;
    localparam int ITERM_W = PROD_W - 18;
    localparam int RAW_W   = ITERM_W + 1;
    localparam int SHS_W   = PROD_W - 8;
    localparam int SCALE_W = 49;
    localparam int SRV_W   = 25;

    localparam logic signed [INTEG_WIDTH-1:0] IMAX = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
    localparam logic signed [INTEG_WIDTH-1:0] IMIN = {1'b1, {(INTEG_WIDTH-1){1'b0}}};
    localparam logic signed [SHS_W-1:0] SCALE_HI = SHS_W'(64'sd1 <<< 47);
    localparam logic signed [SHS_W-1:0] SCALE_LO = -SCALE_HI;
    localparam logic signed [RAW_W-1:0] RAW_HI   = RAW_W'(UNITY_Q14);
    localparam logic signed [RAW_W-1:0] RAW_LO   = -RAW_HI;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ERR   = 8'b0000_0010,
        S_MUL_P = 8'b0000_0100,
        S_MUL_S = 8'b0000_1000,
        S_MUL_I = 8'b0001_0000,
        S_MUL_D = 8'b0010_0000,
        S_MUL_V = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   integ_gain_reg;
    logic [LIMIT_W-1:0]  max_target_reg;
    logic [PERIOD_W-1:0] tick_period_reg;
    logic [SPAN_W-1:0]   servo_span_reg;
    logic [CENTER_W-1:0] servo_center_reg;

    // Controller state
    logic signed [INTEG_WIDTH-1:0] integ_reg;

    // Tick working registers
    logic signed [ANGLE_W-1:0] tgt_reg;
    logic signed [ANGLE_W-1:0] meas_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [PTERM_W-1:0] pterm_reg;
    logic signed [RAW_W-1:0]   raw_reg;
    logic signed [STEER_W-1:0] steer_reg;
    logic                      held_reg;
    logic [SERVO_W-1:0]        servo_reg;

    // Output register
    logic                      res_valid_reg;
    logic signed [STEER_W-1:0] res_steer_reg;
    logic [SERVO_W-1:0]        res_servo_reg;
    logic                      res_held_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic sample_beat;
    logic res_load;

    logic signed [ANGLE_W:0]       tgt_wide;
    logic signed [ANGLE_W:0]       lim_wide;
    logic signed [ANGLE_W-1:0]     tgt_lim;
    logic signed [ERR_W-1:0]       err_c;
    logic signed [SHS_W-1:0]       scale_sh;
    logic signed [SCALE_W-1:0]     scale_c;
    logic signed [ITERM_W-1:0]     iterm_c;
    logic signed [INC_W-1:0]       inc_c;
    logic signed [SUM_W-1:0]       integ_sum;
    logic signed [INTEG_WIDTH-1:0] integ_sat;
    logic                          same_sign;
    logic                          beyond;
    logic                          held_c;
    logic signed [STEER_W-1:0]     steer_c;
    logic signed [SRV_W-1:0]       srv_sum;
    logic signed [SRV_W-15:0]      srv_q;
    logic [SERVO_W-1:0]            servo_c;

    assign sample.ready = (state_reg == S_IDLE);
    assign sample_beat  = sample.valid & sample.ready;
    assign cfg.ready    = 1'b1;
    assign res_load     = (state_reg == S_DONE) & (~res_valid_reg | result.ready);

    // Target limit to +-max_target_angle
    always_comb
    begin
        tgt_wide = (ANGLE_W+1)'(sample.target_angle);
        lim_wide = $signed({2'b00, max_target_reg});
        if (tgt_wide > lim_wide)
        begin
            tgt_lim = ANGLE_W'(lim_wide);
        end
        else if (tgt_wide < -lim_wide)
        begin
            tgt_lim = ANGLE_W'(-lim_wide);
        end
        else
        begin
            tgt_lim = sample.target_angle;
        end
    end

    // Error, scaled integral clamp, I term
    assign err_c    = ERR_W'(tgt_reg) - ERR_W'(meas_reg);
    assign scale_sh = $signed(mul_rsp.product[PROD_W-1:8]);
    assign iterm_c  = $signed(mul_rsp.product[PROD_W-1:18]);
    assign inc_c    = $signed(mul_rsp.product[INC_W+3:4]);

    always_comb
    begin
        if (scale_sh > SCALE_HI)
        begin
            scale_c = SCALE_W'(SCALE_HI);
        end
        else if (scale_sh < SCALE_LO)
        begin
            scale_c = SCALE_W'(SCALE_LO);
        end
        else
        begin
            scale_c = SCALE_W'(scale_sh);
        end
    end

    // Anti-windup decision and command clamp
    assign same_sign = ((err_reg > 0) && (integ_reg > 0)) ||
                       ((err_reg < 0) && (integ_reg < 0));
    assign beyond    = (raw_reg > RAW_HI) || (raw_reg < RAW_LO);
    assign held_c    = beyond & same_sign;

    always_comb
    begin
        if (raw_reg > RAW_HI)
        begin
            steer_c = STEER_W'(RAW_HI);
        end
        else if (raw_reg < RAW_LO)
        begin
            steer_c = STEER_W'(RAW_LO);
        end
        else
        begin
            steer_c = STEER_W'(raw_reg);
        end
    end

    // Saturating integrator update
    assign integ_sum = SUM_W'(integ_reg) + SUM_W'(inc_c);

    always_comb
    begin
        if (integ_sum > SUM_W'(IMAX))
        begin
            integ_sat = IMAX;
        end
        else if (integ_sum < SUM_W'(IMIN))
        begin
            integ_sat = IMIN;
        end
        else
        begin
            integ_sat = integ_sum[INTEG_WIDTH-1:0];
        end
    end

    // Servo mapping, round half up, saturate to 0..180
    assign srv_sum = $signed(mul_rsp.product[SRV_W-1:0]) +
                     $signed({1'b0, servo_center_reg, 14'd0}) +
                     SRV_W'(1 << 13);
    assign srv_q   = srv_sum[SRV_W-1:14];

    always_comb
    begin
        if (srv_q < 0)
        begin
            servo_c = '0;
        end
        else if (srv_q > (SRV_W-14)'(SERVO_MAX))
        begin
            servo_c = SERVO_W'(SERVO_MAX);
        end
        else
        begin
            servo_c = srv_q[SERVO_W-1:0];
        end
    end

    // Next state and multiplier launches
    always_comb
    begin
        state_next        = state_reg;
        mul_req.start     = 1'b0;
        mul_req.is_signed = 1'b0;
        mul_req.digits    = MUL_CNT_W'(MUL_DIGITS);
        mul_req.mcand     = PROD_W'(err_c);
        mul_req.mplier    = prop_gain_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_beat)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                mul_req.start = 1'b1;
                state_next    = S_MUL_P;
            end
            S_MUL_P:
            begin
                mul_req.mcand  = PROD_W'(integ_reg);
                mul_req.mplier = integ_gain_reg;
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    state_next    = S_MUL_S;
                end
            end
            S_MUL_S:
            begin
                mul_req.mcand     = PROD_W'(scale_c);
                mul_req.mplier    = speed_reg;
                mul_req.is_signed = 1'b1;
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    state_next    = S_MUL_I;
                end
            end
            S_MUL_I:
            begin
                mul_req.mcand  = PROD_W'(err_reg);
                mul_req.mplier = tick_period_reg;
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    state_next    = S_MUL_D;
                end
            end
            S_MUL_D:
            begin
                mul_req.mcand  = PROD_W'(steer_c);
                mul_req.mplier = MPLIER_W'(servo_span_reg);
                mul_req.digits = MUL_CNT_W'(SPAN_DIGITS);
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    state_next    = S_MUL_V;
                end
            end
            S_MUL_V:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, configuration and integrator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            res_valid_reg    <= 1'b0;
            integ_reg        <= '0;
            prop_gain_reg    <= PROP_GAIN_RST;
            integ_gain_reg   <= INTEG_GAIN_RST;
            max_target_reg   <= MAX_TARGET_RST;
            tick_period_reg  <= TICK_PERIOD_RST;
            servo_span_reg   <= SERVO_SPAN_RST;
            servo_center_reg <= SERVO_CENTER_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if ((state_reg == S_MUL_D) && mul_rsp.done && !held_c)
            begin
                integ_reg <= integ_sat;
            end

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_PROP_GAIN:    prop_gain_reg    <= cfg.data;
                    CFG_INTEG_GAIN:   integ_gain_reg   <= cfg.data;
                    CFG_MAX_TARGET:   max_target_reg   <= cfg.data[LIMIT_W-1:0];
                    CFG_TICK_PERIOD:  tick_period_reg  <= cfg.data;
                    CFG_SERVO_SPAN:   servo_span_reg   <= cfg.data[SPAN_W-1:0];
                    CFG_SERVO_CENTER: servo_center_reg <= cfg.data[CENTER_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Tick datapath registers
    always_ff @(posedge clk)
    begin
        if (sample_beat)
        begin
            tgt_reg   <= tgt_lim;
            meas_reg  <= sample.measured_angle;
            speed_reg <= sample.vehicle_speed;
        end
        if (state_reg == S_ERR)
        begin
            err_reg <= err_c;
        end
        if ((state_reg == S_MUL_P) && mul_rsp.done)
        begin
            pterm_reg <= $signed(mul_rsp.product[PTERM_W+5:6]);
        end
        if ((state_reg == S_MUL_I) && mul_rsp.done)
        begin
            raw_reg <= RAW_W'(pterm_reg) + RAW_W'(iterm_c);
        end
        if ((state_reg == S_MUL_D) && mul_rsp.done)
        begin
            held_reg  <= held_c;
            steer_reg <= steer_c;
        end
        if ((state_reg == S_MUL_V) && mul_rsp.done)
        begin
            servo_reg <= servo_c;
        end
        if (res_load)
        begin
            res_steer_reg <= steer_reg;
            res_servo_reg <= servo_reg;
            res_held_reg  <= held_reg;
        end
    end

    hapi_serial_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign result.valid         = res_valid_reg;
    assign result.steer_command = res_steer_reg;
    assign result.servo_degrees = res_servo_reg;
    assign result.integ_held    = res_held_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench - regression for the hitch angle PI steering loop
// Drives control ticks and register writes through the channel interfaces,
// predicts each steering result with a fixed-point model of the PI law with
// clamping anti-windup (directed rows may give their expected result
// directly), and checks each result beat in order. A directed plan covers
// the field extremes and corner cases, followed by randomized phases with
// random register settings and random idling on both channels.
module testbench;
    import hapi_pkg::*;

    localparam int     INTEG_W         = INTEG_WIDTH_DEF;
    localparam int     PHASES          = 11;
    localparam int     ITEMS_PER_PHASE = 135;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     MAX_SHOWN       = 10;
    localparam int     TIMEOUT_NS      = 5_000_000;
    localparam longint SCALED_LIM      = 64'sd1 <<< 47;
    localparam longint ROUND_HALF      = 64'sd1 <<< 13;

    // Indexes outside the register map; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [STEER_W-1:0] steer;
        logic [SERVO_W-1:0]        servo;
        logic                      held;
    } steer_out_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     data;
        logic signed [ANGLE_W-1:0] tgt;
        logic signed [ANGLE_W-1:0] meas;
        logic signed [SPEED_W-1:0] spd;
        logic                      typed;
        steer_out_t                out;
    } plan_row_t;

    logic clk;
    logic rst_n;

    hapi_sample_if sample_ch ();
    hapi_result_if result_ch ();
    hapi_cfg_if    cfg_ch ();

    // Controller copy: registers and integrator
    longint prop_gain_r;
    longint integ_gain_r;
    longint max_target_r;
    longint tick_period_r;
    longint servo_span_r;
    longint servo_center_r;
    longint integrator;

    steer_out_t steer_expect_q[$];
    int         mismatches = 0;
    bit         idling;
    int         stall_left = 0;

    hitch_angle_pi_steering_loop #(
        .INTEG_WIDTH (INTEG_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // One control tick: returns the expected result and advances the integrator
    function automatic steer_out_t hitch_tick(input logic signed [ANGLE_W-1:0] tgt_in,
                                              input logic signed [ANGLE_W-1:0] meas_in,
                                              input logic signed [SPEED_W-1:0] speed_in);
        longint     tgt;
        longint     err;
        longint     pterm;
        longint     scaled;
        longint     iterm;
        longint     raw;
        longint     steer;
        longint     servo;
        longint     imax;
        longint     speed;
        bit         same_sign;
        bit         held;
        steer_out_t res;

        speed  = speed_in;
        tgt    = clip(longint'(tgt_in), -max_target_r, max_target_r);
        err    = tgt - longint'(meas_in);
        pterm  = (prop_gain_r * err) >>> 6;
        scaled = clip((integrator * integ_gain_r) >>> 8, -SCALED_LIM, SCALED_LIM);
        iterm  = (scaled * speed) >>> 18;
        raw    = pterm + iterm;

        // clamping anti-windup: hold only when saturated and pushing further
        same_sign = (err > 0 && integrator > 0) || (err < 0 && integrator < 0);
        held      = (raw > UNITY_Q14 || raw < -UNITY_Q14) && same_sign;
        imax      = (64'sd1 <<< (INTEG_W - 1)) - 1;
        if (!held)
            integrator = clip(integrator + ((err * tick_period_r) >>> 4), -imax - 1, imax);

        steer = clip(raw, -UNITY_Q14, UNITY_Q14);
        servo = (steer * servo_span_r + (servo_center_r <<< 14) + ROUND_HALF) >>> 14;
        servo = clip(servo, 0, SERVO_MAX);

        res.steer = STEER_W'(steer);
        res.servo = SERVO_W'(servo);
        res.held  = held;
        return res;
    endfunction

    function automatic plan_row_t tick_row(input logic signed [ANGLE_W-1:0] t,
                                           input logic signed [ANGLE_W-1:0] m,
                                           input logic signed [SPEED_W-1:0] s);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_TICK;
        row.idx  = CFG_PROP_GAIN;
        row.tgt  = t;
        row.meas = m;
        row.spd  = s;
        return row;
    endfunction

    function automatic plan_row_t tick_typed(input logic signed [ANGLE_W-1:0] t,
                                             input logic signed [ANGLE_W-1:0] m,
                                             input logic signed [SPEED_W-1:0] s,
                                             input logic signed [STEER_W-1:0] steer,
                                             input logic [SERVO_W-1:0] servo,
                                             input logic held);
        plan_row_t row;
        row           = tick_row(t, m, s);
        row.typed     = 1'b1;
        row.out.steer = steer;
        row.out.servo = servo;
        row.out.held  = held;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    // Register value for a random phase: extremes, raw noise, or a usable setting
    function automatic logic [CFG_DATA_W-1:0] pick_reg(input logic [CFG_IDX_W-1:0] idx);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return CFG_DATA_W'($urandom);
            default:
            begin
                case (idx)
                    CFG_PROP_GAIN:    return CFG_DATA_W'($urandom_range(64, 2048));
                    CFG_INTEG_GAIN:   return CFG_DATA_W'($urandom_range(0, 1024));
                    CFG_MAX_TARGET:   return CFG_DATA_W'($urandom_range(1024, 12000));
                    CFG_TICK_PERIOD:  return CFG_DATA_W'($urandom_range(64, 4096));
                    CFG_SERVO_SPAN:   return CFG_DATA_W'($urandom_range(0, 90));
                    CFG_SERVO_CENTER: return CFG_DATA_W'($urandom_range(0, 180));
                    default:          return CFG_DATA_W'($urandom);
                endcase
            end
        endcase
    endfunction

    // Register write beat; valid is left high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_PROP_GAIN:    prop_gain_r    = data;
            CFG_INTEG_GAIN:   integ_gain_r   = data;
            CFG_MAX_TARGET:   max_target_r   = data[LIMIT_W-1:0];
            CFG_TICK_PERIOD:  tick_period_r  = data;
            CFG_SERVO_SPAN:   servo_span_r   = data[SPAN_W-1:0];
            CFG_SERVO_CENTER: servo_center_r = data[CENTER_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Sample beat, with an optional idle burst in front of it
    task automatic send_tick(input logic signed [ANGLE_W-1:0] t,
                             input logic signed [ANGLE_W-1:0] m,
                             input logic signed [SPEED_W-1:0] s,
                             input bit typed,
                             input steer_out_t typed_out);
        steer_out_t predicted;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.target_angle   <= t;
        sample_ch.measured_angle <= m;
        sample_ch.vehicle_speed  <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predicted = hitch_tick(t, m, s);
        steer_expect_q.push_back(typed ? typed_out : predicted);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (steer_expect_q.size() != 0)
            @(negedge clk);
    endtask

    // Random phase traffic: tracking runs, windup runs and raw noise
    task automatic run_random_items(input int n);
        int sent;
        int len;
        int kind;
        int sp;
        int spd;
        bit sgn;
        sent = 0;
        while (sent < n)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 12)
            begin
                // measured angle hovering around a setpoint at a steady speed
                len = $urandom_range(6, 20);
                sp  = int'($urandom_range(0, 16000)) - 8000;
                spd = int'($urandom_range(0, 6000)) - 3000;
                repeat (len)
                    send_tick(ANGLE_W'(sp),
                              ANGLE_W'(sp + int'($urandom_range(0, 4000)) - 2000),
                              SPEED_W'(spd + int'($urandom_range(0, 200)) - 100),
                              1'b0, '0);
            end
            else if (kind < 15)
            begin
                // error pinned at one sign to drive the integrator into its limits
                len = $urandom_range(6, 14);
                sgn = $urandom_range(0, 1);
                repeat (len)
                    send_tick(sgn ? 16'sh7FFF : 16'sh8000, sgn ? 16'sh8000 : 16'sh7FFF,
                              SPEED_W'($urandom), 1'b0, '0);
            end
            else
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                    send_tick(ANGLE_W'($urandom), ANGLE_W'($urandom), SPEED_W'($urandom),
                              1'b0, '0);
            end
            sent += len;
        end
    endtask

    // Result channel backpressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (idling && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
        result_ch.ready <= (stall_left == 0);
    end

    // Result checker
    always @(posedge clk)
    begin : check_results
        steer_out_t got;
        steer_out_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.steer = result_ch.steer_command;
            got.servo = result_ch.servo_degrees;
            got.held  = result_ch.integ_held;
            if (steer_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: unexpected result beat: steer %0d servo %0d held %0d",
                             $time, $signed(got.steer), got.servo, got.held);
            end
            else
            begin
                want = steer_expect_q.pop_front();
                if (got.steer !== want.steer || got.servo !== want.servo ||
                    got.held !== want.held)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"%0t: result mismatch: steer exp %0d got %0d, ",
                                  "servo exp %0d got %0d, held exp %0d got %0d"},
                                 $time, $signed(want.steer), $signed(got.steer),
                                 want.servo, got.servo, want.held, got.held);
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #TIMEOUT_NS;
        $display("hitch_angle_pi_steering_loop regression: fail");
        $finish;
    end

    // Stimulus
    initial
    begin
        plan_row_t plan[$];

        clk                      = 1'b0;
        rst_n                    = 1'b0;
        sample_ch.valid          = 1'b0;
        sample_ch.target_angle   = '0;
        sample_ch.measured_angle = '0;
        sample_ch.vehicle_speed  = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = CFG_PROP_GAIN;
        cfg_ch.data              = '0;
        idling                   = 1'b1;

        prop_gain_r    = PROP_GAIN_RST;
        integ_gain_r   = INTEG_GAIN_RST;
        max_target_r   = MAX_TARGET_RST;
        tick_period_r  = TICK_PERIOD_RST;
        servo_span_r   = SERVO_SPAN_RST;
        servo_center_r = SERVO_CENTER_RST;
        integrator     = 0;

        // Directed plan, starting from reset settings
        plan.push_back(tick_typed(0, 0, 0, 0, 90, 0));
        plan.push_back(tick_typed(32767, -32768, 0, 16384, 120, 0));
        plan.push_back(tick_typed(32767, -32768, 0, 16384, 120, 1));
        plan.push_back(tick_typed(-32768, 32767, 0, -16384, 60, 0));
        plan.push_back(tick_row(4096, 4095, 32767));
        plan.push_back(tick_row(-1, 0, -32768));
        plan.push_back(tick_row(1, -1, -1));
        plan.push_back(tick_row(0, 32767, 256));
        // full integral gain and step: speed-scaled integral term in play
        plan.push_back(reg_row(CFG_INTEG_GAIN, '1));
        plan.push_back(reg_row(CFG_TICK_PERIOD, '1));
        plan.push_back(tick_row(2000, 0, 32767));
        plan.push_back(tick_row(-2000, 0, -32768));
        plan.push_back(tick_row(100, -100, 1));
        // zero target limit forces the target to zero
        plan.push_back(reg_row(CFG_MAX_TARGET, '0));
        plan.push_back(tick_typed(32767, 0, 0, 0, 90, 0));
        plan.push_back(tick_typed(-32768, 100, 0, -400, 89, 0));
        // span and center beyond their ranges, servo saturates
        plan.push_back(reg_row(CFG_SERVO_SPAN, '1));
        plan.push_back(reg_row(CFG_SERVO_CENTER, '1));
        plan.push_back(tick_typed(0, 0, 0, 0, 180, 0));
        plan.push_back(tick_row(0, -32768, 0));
        plan.push_back(reg_row(CFG_SERVO_CENTER, '0));
        plan.push_back(reg_row(CFG_PROP_GAIN, '1));
        plan.push_back(tick_row(0, 32767, 0));
        plan.push_back(tick_row(0, 1, 0));
        // writes to unmapped indexes change nothing
        plan.push_back(reg_row(CFG_SPARE_6, '1));
        plan.push_back(reg_row(CFG_SPARE_7, 16'h5A5A));
        plan.push_back(tick_row(0, 0, 0));
        // all gains and servo settings at zero, widest limit
        plan.push_back(reg_row(CFG_PROP_GAIN, '0));
        plan.push_back(reg_row(CFG_INTEG_GAIN, '0));
        plan.push_back(reg_row(CFG_TICK_PERIOD, '0));
        plan.push_back(reg_row(CFG_SERVO_SPAN, '0));
        plan.push_back(reg_row(CFG_SERVO_CENTER, '0));
        plan.push_back(reg_row(CFG_MAX_TARGET, '1));
        plan.push_back(tick_typed(32767, -32768, -32768, 0, 0, 0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                sample_ch.valid <= 1'b0;
                wait_idle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                cfg_ch.valid <= 1'b0;
                send_tick(plan[i].tgt, plan[i].meas, plan[i].spd, plan[i].typed,
                          plan[i].out);
            end
        end

        // Integrator saturation: no gain, largest step, error held at one sign, then at the other
        sample_ch.valid <= 1'b0;
        wait_idle();
        write_reg(CFG_PROP_GAIN, '0);
        write_reg(CFG_INTEG_GAIN, '0);
        write_reg(CFG_TICK_PERIOD, '1);
        write_reg(CFG_MAX_TARGET, '1);
        cfg_ch.valid <= 1'b0;
        repeat (12)
            send_tick(16'sh7FFF, 16'sh8000, SPEED_W'($urandom), 1'b0, '0);
        repeat (20)
            send_tick(16'sh8000, 16'sh7FFF, SPEED_W'($urandom), 1'b0, '0);

        // Random phases, each under fresh register settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            sample_ch.valid <= 1'b0;
            wait_idle();
            idling = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int r = CFG_PROP_GAIN; r <= CFG_SERVO_CENTER; r++)
                write_reg(CFG_IDX_W'(r), pick_reg(CFG_IDX_W'(r)));
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                          CFG_DATA_W'($urandom));
            cfg_ch.valid <= 1'b0;
            run_random_items(ITEMS_PER_PHASE);
        end

        sample_ch.valid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("hitch_angle_pi_steering_loop regression: pass");
        else
            $display("hitch_angle_pi_steering_loop regression: fail");
        $finish;
    end

endmodule

// ===== hitch_angle_pi_steering_loop.f =====
hw/rtl/hapi_pkg.sv
hw/rtl/hapi_if.sv
hw/rtl/hapi_serial_mul.sv
hw/rtl/hitch_angle_pi_steering_loop.sv
tb/testbench.sv
